@@ hdl/duration_string_parser_assert.svh @@
// ----------------------------------------------------------------------------
// duration string parser assertion macros
// concurrent checks sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef DURATION_STRING_PARSER_ASSERT_SVH
`define DURATION_STRING_PARSER_ASSERT_SVH

// same-cycle implication
`define DSP_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSP_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/dsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dsp_pkg
// shared types, constants and helper functions of the duration string parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsp_pkg;

	typedef logic [30:0] sec_t;
	typedef logic [25:0] min_t;

	localparam sec_t SEC_MAX = 31'h7FFF_FFFF;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	// floor(x / 60) = (x * MIN_RECIP) >> MIN_SHIFT for x below 2**31
	localparam logic [31:0] MIN_RECIP = 32'd2290649225;
	localparam int unsigned MIN_SHIFT = 37;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_CASE  = 8'h20;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_S     = 8'h73;

	localparam logic [16:0] MULT_DAY  = 17'd86400;
	localparam logic [16:0] MULT_HOUR = 17'd3600;
	localparam logic [16:0] MULT_MIN  = 17'd60;
	localparam logic [16:0] MULT_SEC  = 17'd1;

	typedef enum logic [2:0] {
		K_BLANK,
		K_DIGIT,
		K_UNIT,
		K_OTHER,
		K_END
	} kind_t;

	typedef enum logic [1:0] {
		U_DAY,
		U_HOUR,
		U_MIN,
		U_SEC
	} unit_t;

	typedef enum logic [2:0] {
		PH_EXPECT,
		PH_NUMBER,
		PH_AFTER,
		PH_TAIL,
		PH_FAIL
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SYNTAX,
		ST_OVERFLOW
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		unit_t      unit;
	} token_t;

	typedef struct packed {
		status_t status;
		sec_t    seconds;
	} result_t;

	function automatic token_t classify(input logic [7:0] c);
		token_t     t;
		logic [7:0] lc;
		t.kind  = K_OTHER;
		t.digit = c[3:0];
		t.unit  = U_SEC;
		lc      = (c inside {[CH_UP_A:CH_UP_Z]}) ? (c | CH_CASE) : c;
		if (c == CH_END) begin
			t.kind = K_END;
		end else if (c == CH_SPACE || c == CH_TAB) begin
			t.kind = K_BLANK;
		end else if (c inside {[CH_ZERO:CH_NINE]}) begin
			t.kind = K_DIGIT;
		end else begin
			case (lc)
				CH_D: begin
					t.kind = K_UNIT;
					t.unit = U_DAY;
				end
				CH_H: begin
					t.kind = K_UNIT;
					t.unit = U_HOUR;
				end
				CH_M: begin
					t.kind = K_UNIT;
					t.unit = U_MIN;
				end
				CH_S: begin
					t.kind = K_UNIT;
					t.unit = U_SEC;
				end
				default: begin
					t.kind = K_OTHER;
				end
			endcase
		end
		return t;
	endfunction

	function automatic logic [16:0] unit_mult(input unit_t u);
		logic [16:0] m;
		case (u)
			U_DAY:   m = MULT_DAY;
			U_HOUR:  m = MULT_HOUR;
			U_MIN:   m = MULT_MIN;
			U_SEC:   m = MULT_SEC;
			default: m = MULT_SEC;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ hdl/dsp_front.sv @@
// ----------------------------------------------------------------------------
// dsp_front
// accepts characters, classifies them and queues the tokens for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      ch,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output dsp_pkg::token_t      q_tok,
	output logic                 q_vld,
	input  wire logic            q_pop
);

	dsp_pkg::token_t                 mem_q [dsp_pkg::QDEPTH];
	logic [dsp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [dsp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [dsp_pkg::QCNT_W-1:0]      cnt_q;
	logic                            push;
	logic                            pop;

	assign in_stall = (cnt_q == dsp_pkg::QCNT_W'(dsp_pkg::QDEPTH));
	assign q_vld    = (cnt_q != '0);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_vld;
	assign q_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dsp_pkg::classify(ch);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/dsp_back.sv @@
// ----------------------------------------------------------------------------
// dsp_back
// parse state machine with scaled product, then total accumulation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dsp_pkg::token_t tok,
	input  wire logic            tok_vld,
	output logic                 tok_pop,
	input  wire logic            adv,
	output logic                 res_vld,
	output dsp_pkg::result_t     res
);

	// stage 1 parse state
	dsp_pkg::phase_t  phase_q, phase_d;
	dsp_pkg::sec_t    cur_q, cur_d;
	logic             unit_seen_q, unit_seen_d;
	logic             num_ovf_q, num_ovf_d;
	logic             add;
	logic             fail;
	logic             is_end;
	logic [16:0]      mult;
	logic [34:0]      next_num;
	logic [47:0]      prod_full;

	// stage 2 accumulate
	logic             vld_s2;
	logic             end_s2;
	logic             fail_s2;
	logic             novf_s2;
	logic             add_s2;
	dsp_pkg::sec_t    prod_s2;
	logic             pov_s2;
	dsp_pkg::sec_t    total_q;
	logic             tovf_q;
	logic [31:0]      sum;
	logic             sum_ov;
	dsp_pkg::sec_t    tot_new;
	logic             tovf_new;
	dsp_pkg::result_t res_d;

	// stage 3 result
	logic             vld_s3;
	dsp_pkg::result_t res_s3;

	assign tok_pop   = adv && tok_vld;
	assign next_num  = 35'({cur_q, 3'b000}) + 35'({cur_q, 1'b0}) + 35'(tok.digit);
	assign prod_full = 48'(cur_q) * 48'(mult);

	always_comb begin
		phase_d     = phase_q;
		cur_d       = cur_q;
		unit_seen_d = unit_seen_q;
		num_ovf_d   = num_ovf_q;
		add         = 1'b0;
		fail        = 1'b0;
		is_end      = 1'b0;
		mult        = dsp_pkg::unit_mult(tok.unit);
		if (tok.kind == dsp_pkg::K_END) begin
			is_end      = 1'b1;
			mult        = dsp_pkg::MULT_MIN;
			phase_d     = dsp_pkg::PH_EXPECT;
			cur_d       = '0;
			unit_seen_d = 1'b0;
			num_ovf_d   = 1'b0;
			case (phase_q)
				dsp_pkg::PH_EXPECT: begin
					fail = !unit_seen_q;
				end
				dsp_pkg::PH_NUMBER, dsp_pkg::PH_AFTER: begin
					fail = unit_seen_q;
					add  = !unit_seen_q;
				end
				dsp_pkg::PH_TAIL: begin
					fail = 1'b0;
				end
				default: begin
					fail = 1'b1;
				end
			endcase
		end else begin
			case (phase_q)
				dsp_pkg::PH_EXPECT: begin
					if (tok.kind == dsp_pkg::K_DIGIT) begin
						cur_d   = 31'(tok.digit);
						phase_d = dsp_pkg::PH_NUMBER;
					end else if (tok.kind != dsp_pkg::K_BLANK) begin
						phase_d = unit_seen_q ? dsp_pkg::PH_TAIL : dsp_pkg::PH_FAIL;
					end
				end
				dsp_pkg::PH_NUMBER: begin
					case (tok.kind)
						dsp_pkg::K_DIGIT: begin
							if (next_num > 35'(dsp_pkg::SEC_MAX)) begin
								num_ovf_d = 1'b1;
								cur_d     = dsp_pkg::SEC_MAX;
							end else begin
								cur_d = next_num[30:0];
							end
						end
						dsp_pkg::K_BLANK: begin
							phase_d = dsp_pkg::PH_AFTER;
						end
						dsp_pkg::K_UNIT: begin
							add         = 1'b1;
							cur_d       = '0;
							unit_seen_d = 1'b1;
							phase_d     = dsp_pkg::PH_EXPECT;
						end
						default: begin
							phase_d = dsp_pkg::PH_FAIL;
						end
					endcase
				end
				dsp_pkg::PH_AFTER: begin
					if (tok.kind == dsp_pkg::K_UNIT) begin
						add         = 1'b1;
						cur_d       = '0;
						unit_seen_d = 1'b1;
						phase_d     = dsp_pkg::PH_EXPECT;
					end else if (tok.kind != dsp_pkg::K_BLANK) begin
						phase_d = dsp_pkg::PH_FAIL;
					end
				end
				dsp_pkg::PH_TAIL: begin
					phase_d = dsp_pkg::PH_TAIL;
				end
				default: begin
					phase_d = dsp_pkg::PH_FAIL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dsp_pkg::PH_EXPECT;
			cur_q       <= '0;
			unit_seen_q <= 1'b0;
			num_ovf_q   <= 1'b0;
		end else if (tok_pop) begin
			phase_q     <= phase_d;
			cur_q       <= cur_d;
			unit_seen_q <= unit_seen_d;
			num_ovf_q   <= num_ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= tok_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			end_s2  <= is_end;
			fail_s2 <= fail;
			novf_s2 <= num_ovf_q;
			add_s2  <= add;
			pov_s2  <= (prod_full > 48'(dsp_pkg::SEC_MAX));
			prod_s2 <= (prod_full > 48'(dsp_pkg::SEC_MAX)) ? dsp_pkg::SEC_MAX
				: prod_full[30:0];
		end
	end

	always_comb begin
		sum      = 32'(total_q) + 32'(prod_s2);
		sum_ov   = pov_s2 || sum[31];
		tot_new  = total_q;
		tovf_new = tovf_q;
		if (add_s2) begin
			tot_new  = sum_ov ? dsp_pkg::SEC_MAX : sum[30:0];
			tovf_new = tovf_q || sum_ov;
		end
		if (fail_s2) begin
			res_d.status = dsp_pkg::ST_SYNTAX;
		end else if (tovf_new || novf_s2) begin
			res_d.status = dsp_pkg::ST_OVERFLOW;
		end else begin
			res_d.status = dsp_pkg::ST_OK;
		end
		res_d.seconds = (res_d.status == dsp_pkg::ST_OK) ? tot_new : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			tovf_q  <= 1'b0;
			vld_s3  <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2 && end_s2;
			if (vld_s2) begin
				total_q <= end_s2 ? '0 : tot_new;
				tovf_q  <= end_s2 ? 1'b0 : tovf_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2 && end_s2) begin
			res_s3 <= res_d;
		end
	end

	assign res_vld = vld_s3;
	assign res     = res_s3;

endmodule

`default_nettype wire

@@ hdl/dsp_out.sv @@
// ----------------------------------------------------------------------------
// dsp_out
// minutes by reciprocal multiply and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsp_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_vld,
	input  wire dsp_pkg::result_t res,
	output logic                  adv,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output logic [30:0]           total_seconds,
	output logic [25:0]           total_minutes
);

	logic              vld_q;
	dsp_pkg::status_t  status_q;
	dsp_pkg::sec_t     sec_q;
	dsp_pkg::min_t     min_q;
	logic [62:0]       recip_prod;

	assign adv        = !vld_q || !out_stall;
	assign recip_prod = 63'(res.seconds) * 63'(dsp_pkg::MIN_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			status_q <= res.status;
			sec_q    <= res.seconds;
			min_q    <= recip_prod[dsp_pkg::MIN_SHIFT +: 26];
		end
	end

	assign out_valid     = vld_q;
	assign status        = status_q;
	assign total_seconds = sec_q;
	assign total_minutes = min_q;

endmodule

`default_nettype wire

@@ hdl/duration_string_parser.sv @@
// a result passes the token queue, then the stage-2, stage-3 and output registers
// throughput: one character per cycle unless in_stall is high; a four-entry
// token queue lets input continue while a result waits in the output register
// reset: arst_n clears the parse state, running total, queue and stage valids
// ----------------------------------------------------------------------------
// duration_string_parser
// parses duration strings into seconds and minutes with overflow and syntax flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "duration_string_parser_assert.svh"

module duration_string_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  ch,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [30:0]      total_seconds,
	output logic [25:0]      total_minutes
);

	dsp_pkg::token_t  q_tok;
	logic             q_vld;
	logic             q_pop;
	logic             adv;
	logic             res_vld;
	dsp_pkg::result_t res;

	dsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_tok    (q_tok),
		.q_vld    (q_vld),
		.q_pop    (q_pop)
	);

	dsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok     (q_tok),
		.tok_vld (q_vld),
		.tok_pop (q_pop),
		.adv     (adv),
		.res_vld (res_vld),
		.res     (res)
	);

	dsp_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_vld       (res_vld),
		.res           (res),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.total_seconds (total_seconds),
		.total_minutes (total_minutes)
	);

	`DSP_ASSERT_NOW(a_err_zero, out_valid && status != 2'(dsp_pkg::ST_OK),
		total_seconds == '0 && total_minutes == '0, "non-ok item carries nonzero totals")
	`DSP_ASSERT_NOW(a_min_match, out_valid,
		(32'(total_minutes) * 32'd60 <= 32'(total_seconds)) &&
		(32'(total_seconds) - 32'(total_minutes) * 32'd60 < 32'd60),
		"minutes do not match seconds")
	`DSP_ASSERT_NXT(a_push_lands, in_valid && !in_stall, q_vld,
		"accepted item missing from queue")

endmodule

`default_nettype wire
